// ----- rtl/xxh32_stream_hash_macros.svh -----
// ----------------------------------------------------------------------------
// xxh32_stream_hash_macros.svh
// Assertion helpers for the XXH32 stream hash block.
// ----------------------------------------------------------------------------
`ifndef XXH32_STREAM_HASH_MACROS_SVH
`define XXH32_STREAM_HASH_MACROS_SVH

// Property checked on every clock edge outside reset.
`define XXH32_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define XXH32_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/xxh32_pkg.sv -----
// ----------------------------------------------------------------------------
// xxh32_pkg
// Primes, sequencer states and multiplier constant select for XXH32.
// ----------------------------------------------------------------------------
package xxh32_pkg;

    localparam logic [31:0] PRIME1 = 32'h9E37_79B1;
    localparam logic [31:0] PRIME2 = 32'h85EB_CA77;
    localparam logic [31:0] PRIME3 = 32'hC2B2_AE3D;
    localparam logic [31:0] PRIME4 = 32'h27D4_EB2F;
    localparam logic [31:0] PRIME5 = 32'h1656_67B1;

    // constant operand of the shared multiplier
    typedef enum logic [2:0] {
        K_P1,
        K_P2,
        K_P3,
        K_P4,
        K_P5
    } mul_k_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LANE_A,
        ST_LANE_B,
        ST_LANE_W,
        ST_MERGE,
        ST_FOLD_A,
        ST_FOLD_B,
        ST_FOLD_C,
        ST_AVAL_A,
        ST_AVAL_B,
        ST_OUT
    } state_t;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

// ----- rtl/xxh32_mul.sv -----
// ----------------------------------------------------------------------------
// xxh32_mul
// Shared 32x32 multiplier, low 32 bits of the operand times a selected prime,
// result registered.
// ----------------------------------------------------------------------------
module xxh32_mul import xxh32_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  mul_k_t      k_sel,
    output logic [31:0] p
);

    logic [31:0] k;
    logic [31:0] p_reg;
    logic [31:0] p_next;

    always_comb begin
        unique case (k_sel)
            K_P1:    k = PRIME1;
            K_P2:    k = PRIME2;
            K_P3:    k = PRIME3;
            K_P4:    k = PRIME4;
            K_P5:    k = PRIME5;
            default: k = PRIME1;
        endcase
    end

    assign p_next = a * k;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- rtl/xxh32_stream_hash.sv -----
// ----------------------------------------------------------------------------
// xxh32_stream_hash
// Streaming XXH32 over little-endian 32-bit words, one 32x32 multiplier
// shared by a small sequencer.
// ----------------------------------------------------------------------------
// A message arrives as beats of up to four bytes; only the last beat may be
// short, and an empty message is a single last beat with zero bytes. The
// seed register is sampled at the first beat of a message for the lanes and
// in the merge step after the last beat for the short-message path. Throughput is
// set by the single multiplier: a plain word is taken without a stall; a word that
// completes a 16-byte stripe runs four lane rounds of two multiplies each (lane A,
// lane B, write-back); a last beat adds the merge, a fold per buffered word and per
// tail byte, and the avalanche, plus any wait for the result register to drain. s_tready is low meanwhile.
`include "xxh32_stream_hash_macros.svh"

module xxh32_stream_hash import xxh32_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] hash
);

    state_t      state_reg, state_next;
    logic [31:0] seed_reg;
    logic [31:0] lane_reg [4];
    logic [31:0] buf_reg [4];
    logic [1:0]  wis_reg;
    logic [31:0] len_reg;
    logic        in_msg_reg;
    logic        large_reg;
    logic [31:0] word_reg;
    logic [1:0]  tail_reg;
    logic        last_reg;
    logic [1:0]  idx_reg;
    logic        bytes_reg;
    logic [31:0] h_reg;
    logic [31:0] out_reg;
    logic        out_valid_reg;

    logic        mul_en;
    logic [31:0] mul_a;
    mul_k_t      mul_k;
    logic [31:0] prod;

    logic        accept;
    logic        full_word;
    logic [2:0]  cnt;
    logic [1:0]  wis_base;
    logic [31:0] len_base;
    logic        stripe_done;
    logic [1:0]  fold_limit;
    logic        fold_more;
    logic        out_free;
    logic [31:0] merge_h;
    logic [7:0]  tail_byte;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            seed_reg <= pwdata;
        end
    end

    // ---------------- beat decode ----------------
    assign accept      = s_tvalid && s_tready;
    assign full_word   = !s_tlast || (s_tdata[34:32] >= 3'd4);
    assign cnt         = full_word ? 3'd4 : s_tdata[34:32];
    assign wis_base    = in_msg_reg ? wis_reg : 2'd0;
    assign len_base    = in_msg_reg ? len_reg : 32'd0;
    assign stripe_done = full_word && (wis_base == 2'd3);

    assign fold_limit = bytes_reg ? tail_reg : wis_reg;
    assign fold_more  = ({1'b0, idx_reg} + 3'd1) < {1'b0, fold_limit};
    assign out_free   = !out_valid_reg || m_tready;
    assign tail_byte  = word_reg[{idx_reg, 3'b000} +: 8];

    assign merge_h = (large_reg ? (rol32(lane_reg[0], 1) + rol32(lane_reg[1], 7) +
                                   rol32(lane_reg[2], 12) + rol32(lane_reg[3], 18))
                                : (seed_reg + PRIME5)) + len_reg;

    // ---------------- shared multiplier ----------------
    xxh32_mul u_mul (
        .aclk  (aclk),
        .en    (mul_en),
        .a     (mul_a),
        .k_sel (mul_k),
        .p     (prod)
    );

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (stripe_done) begin
                        state_next = ST_LANE_A;
                    end else if (s_tlast) begin
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_LANE_A: state_next = ST_LANE_B;
            ST_LANE_B: state_next = ST_LANE_W;
            ST_LANE_W: begin
                if (idx_reg != 2'd3) begin
                    state_next = ST_LANE_A;
                end else if (last_reg) begin
                    state_next = ST_MERGE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MERGE: begin
                if (wis_reg != 2'd0 || tail_reg != 2'd0) begin
                    state_next = ST_FOLD_A;
                end else begin
                    state_next = ST_AVAL_A;
                end
            end
            ST_FOLD_A: state_next = ST_FOLD_B;
            ST_FOLD_B: state_next = ST_FOLD_C;
            ST_FOLD_C: begin
                if (fold_more || (!bytes_reg && tail_reg != 2'd0)) begin
                    state_next = ST_FOLD_A;
                end else begin
                    state_next = ST_AVAL_A;
                end
            end
            ST_AVAL_A: state_next = ST_AVAL_B;
            ST_AVAL_B: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready = 1'b0;
        mul_en   = 1'b0;
        mul_a    = 32'd0;
        mul_k    = K_P1;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_LANE_A: begin
                mul_en = 1'b1;
                mul_a  = buf_reg[idx_reg];
                mul_k  = K_P2;
            end
            ST_LANE_B: begin
                mul_en = 1'b1;
                mul_a  = rol32(lane_reg[idx_reg] + prod, 13);
                mul_k  = K_P1;
            end
            ST_FOLD_A: begin
                mul_en = 1'b1;
                mul_a  = bytes_reg ? {24'd0, tail_byte} : buf_reg[idx_reg];
                mul_k  = bytes_reg ? K_P5 : K_P3;
            end
            ST_FOLD_B: begin
                mul_en = 1'b1;
                mul_a  = bytes_reg ? rol32(h_reg + prod, 11) : rol32(h_reg + prod, 17);
                mul_k  = bytes_reg ? K_P1 : K_P4;
            end
            ST_AVAL_A: begin
                mul_en = 1'b1;
                mul_a  = h_reg ^ (h_reg >> 15);
                mul_k  = K_P2;
            end
            ST_AVAL_B: begin
                mul_en = 1'b1;
                mul_a  = prod ^ (prod >> 13);
                mul_k  = K_P3;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_msg_reg    <= 1'b0;
            large_reg     <= 1'b0;
            wis_reg       <= 2'd0;
            len_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                in_msg_reg <= 1'b1;
                len_reg    <= len_base + {29'd0, cnt};
                large_reg  <= (in_msg_reg && large_reg) || stripe_done;
                if (full_word) begin
                    wis_reg <= wis_base + 2'd1;  // wraps to zero on a full stripe
                end else begin
                    wis_reg <= wis_base;
                end
            end
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
                in_msg_reg    <= 1'b0;
                large_reg     <= 1'b0;
                wis_reg       <= 2'd0;
                len_reg       <= 32'd0;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!in_msg_reg) begin
                        lane_reg[0] <= seed_reg + PRIME1 + PRIME2;
                        lane_reg[1] <= seed_reg + PRIME2;
                        lane_reg[2] <= seed_reg;
                        lane_reg[3] <= seed_reg - PRIME1;
                    end
                    if (full_word) begin
                        buf_reg[wis_base] <= s_tdata[31:0];
                    end
                    word_reg <= s_tdata[31:0];
                    tail_reg <= full_word ? 2'd0 : s_tdata[33:32];
                    last_reg <= s_tlast;
                    idx_reg  <= 2'd0;
                end
            end
            ST_LANE_W: begin
                lane_reg[idx_reg] <= prod;
                idx_reg           <= idx_reg + 2'd1;
            end
            ST_MERGE: begin
                h_reg     <= merge_h;
                idx_reg   <= 2'd0;
                bytes_reg <= (wis_reg == 2'd0);
            end
            ST_FOLD_C: begin
                h_reg <= prod;
                if (fold_more) begin
                    idx_reg <= idx_reg + 2'd1;
                end else begin
                    // buffered words done, move on to the tail bytes
                    idx_reg   <= 2'd0;
                    bytes_reg <= 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_reg <= prod ^ (prod >> 16);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // ---------------- assertions ----------------
    `XXH32_ASSERT(a_result_from_out, $rose(m_tvalid) |-> $past(state_reg == ST_OUT), "result beat without finalisation")
    `XXH32_ASSERT(a_lane_stripe_clear, (state_reg == ST_LANE_A) |-> (wis_reg == 2'd0), "lane round with partial stripe")
    `XXH32_ASSERT_NEVER(a_fold_in_range, (state_reg == ST_FOLD_B) && (idx_reg >= fold_limit), "fold index past limit")
    `XXH32_ASSERT_NEVER(a_busy_while_ready, s_tready && mul_en, "multiplier busy while taking a beat")

endmodule
